### rtl/lqr_pkg.sv
`timescale 1ns / 1ps

package lqr_pkg;

    // fixed-point format and drive limit
    localparam int FRAC_BITS = 24;
    localparam int DRIVE_MAX = 4095;
    localparam int QW        = 48;
    localparam int PW        = 2 * QW;
    localparam int DW        = QW + FRAC_BITS;
    localparam int DCW       = $clog2(DW);

    localparam longint QMAX_L = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint QMIN_L = -64'sh0000_8000_0000_0000;
    localparam logic signed [QW-1:0] QMAX = QMAX_L[QW-1:0];
    localparam logic signed [QW-1:0] QMIN = QMIN_L[QW-1:0];
    localparam logic signed [QW-1:0] QONE = QW'(64'sd1 <<< FRAC_BITS);

    localparam longint ULIM_L = longint'(DRIVE_MAX) * (64'sd1 <<< FRAC_BITS);
    localparam logic signed [QW-1:0] ULIM = (ULIM_L > QMAX_L) ? QMAX : ULIM_L[QW-1:0];

    // alu operation codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_NSUB  = 3'd2;
    localparam logic [2:0] OP_MUL16 = 3'd3;
    localparam logic [2:0] OP_MULF  = 3'd4;
    localparam logic [2:0] OP_DIV   = 3'd5;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } alu_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [QW-1:0] result;
    } alu_rsp_t;

    // saturate a wide signed value to the q range
    function automatic logic signed [QW-1:0] sat_q(input logic signed [63:0] v);
        if (v > QMAX_L) return QMAX;
        if (v < QMIN_L) return QMIN;
        return v[QW-1:0];
    endfunction

    // magnitude, most negative value maps to 2^47
    function automatic logic [QW-1:0] mag_q(input logic signed [QW-1:0] v);
        return v[QW-1] ? QW'(-v) : QW'(v);
    endfunction

    // signed result from magnitude and sign, saturated
    function automatic logic signed [QW-1:0] from_mag(input logic [PW-1:0] q, input logic neg);
        logic [PW-1:0] lim_neg;
        logic [PW-1:0] lim_pos;
        lim_neg = PW'(1) << (QW - 1);
        lim_pos = lim_neg - PW'(1);
        if (neg) begin
            if (q > lim_neg) return QMIN;
            return -$signed(q[QW-1:0]);
        end
        if (q > lim_pos) return QMAX;
        return $signed(q[QW-1:0]);
    endfunction

    // q32 constant rounded half away from zero to the working fraction
    function automatic logic signed [QW-1:0] const_q(input longint c32);
        int     sh;
        longint m;
        longint r;
        sh = 32 - FRAC_BITS;
        if (sh == 0) return c32[QW-1:0];
        m = (c32 < 0) ? -c32 : c32;
        r = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (c32 < 0) ? QW'(-r) : QW'(r);
    endfunction

endpackage

### rtl/lqr_kalman_state_controller_unit.sv
`timescale 1ns / 1ps
// channel   | dir | ports                      | content
// input     | in  | s_tvalid s_tready s_tdata  | encoder angle per sample
// result    | out | m_tvalid m_tready m_tdata  | duty, direction, brake, drive, estimates
// config    | in  | cfg_wr_en cfg_addr cfg_wdata | register write, no read-back
// each word runs 56 sequencer steps on one shared alu, and a new word is
// accepted only once the last has left the sequencer; multiply steps sum
// three 48x16 partial products, and the two gain divides form one quotient
// bit per cycle.
// reset restores the register defaults and the estimator state at once.
// the result register holds a word until taken; the next word is accepted
// meanwhile, and a finished word waits for the result register to empty.

module lqr_kalman_state_controller_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // angle_deg[8:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // pwm_duty[11:0] turn_cw[12] brake[13] drive_value[26:14]
                                    // est_angle_out[74:27] est_rate_out[122:75]
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [46:0]  cfg_wdata
);

    localparam int QW = lqr_pkg::QW;
    localparam int FB = lqr_pkg::FRAC_BITS;

    // register indexes
    localparam logic [2:0] REG_SETPOINT = 3'd0;
    localparam logic [2:0] REG_OFFSET   = 3'd1;
    localparam logic [2:0] REG_K1       = 3'd2;
    localparam logic [2:0] REG_K2       = 3'd3;
    localparam logic [2:0] REG_KI       = 3'd4;
    localparam logic [2:0] REG_ILIM     = 3'd5;
    localparam logic [2:0] REG_QPROC    = 3'd6;
    localparam logic [2:0] REG_RMEAS    = 3'd7;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // operand and destination codes
    localparam logic [5:0] R_EA   = 6'd0;
    localparam logic [5:0] R_ER   = 6'd1;
    localparam logic [5:0] R_CAA  = 6'd2;
    localparam logic [5:0] R_CAR  = 6'd3;
    localparam logic [5:0] R_CRA  = 6'd4;
    localparam logic [5:0] R_CRR  = 6'd5;
    localparam logic [5:0] R_K1   = 6'd6;
    localparam logic [5:0] R_K2   = 6'd7;
    localparam logic [5:0] R_KI   = 6'd8;
    localparam logic [5:0] R_IQ   = 6'd9;
    localparam logic [5:0] R_A11  = 6'd10;
    localparam logic [5:0] R_A12  = 6'd11;
    localparam logic [5:0] R_A21  = 6'd12;
    localparam logic [5:0] R_A22  = 6'd13;
    localparam logic [5:0] R_B11  = 6'd14;
    localparam logic [5:0] R_B21  = 6'd15;
    localparam logic [5:0] R_U    = 6'd16;
    localparam logic [5:0] R_X1P  = 6'd17;
    localparam logic [5:0] R_X2P  = 6'd18;
    localparam logic [5:0] R_TA   = 6'd19;
    localparam logic [5:0] R_TB   = 6'd20;
    localparam logic [5:0] R_T1   = 6'd21;
    localparam logic [5:0] R_T2   = 6'd22;
    localparam logic [5:0] R_T3   = 6'd23;
    localparam logic [5:0] R_T4   = 6'd24;
    localparam logic [5:0] R_P11  = 6'd25;
    localparam logic [5:0] R_P12  = 6'd26;
    localparam logic [5:0] R_P21  = 6'd27;
    localparam logic [5:0] R_P22  = 6'd28;
    localparam logic [5:0] R_Q    = 6'd29;
    localparam logic [5:0] R_R    = 6'd30;
    localparam logic [5:0] R_S    = 6'd31;
    localparam logic [5:0] R_K1G  = 6'd32;
    localparam logic [5:0] R_K2G  = 6'd33;
    localparam logic [5:0] R_YQ   = 6'd34;
    localparam logic [5:0] R_YERR = 6'd35;
    localparam logic [5:0] R_ONE  = 6'd36;
    localparam logic [5:0] R_OMK  = 6'd37;

    localparam logic [5:0] LAST_STEP = 6'd55;

    // model matrices
    localparam logic signed [QW-1:0] A11 = lqr_pkg::const_q(64'sd4294108303);
    localparam logic signed [QW-1:0] A12 = lqr_pkg::const_q(64'sd42902428);
    localparam logic signed [QW-1:0] A21 = lqr_pkg::const_q(-64'sd150710402);
    localparam logic signed [QW-1:0] A22 = lqr_pkg::const_q(64'sd4285518368);
    localparam logic signed [QW-1:0] B11 = lqr_pkg::const_q(64'sd68032);
    localparam logic signed [QW-1:0] B21 = lqr_pkg::const_q(64'sd490915);

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] src_a;
        logic [5:0] src_b;
        logic [5:0] dst;
    } step_t;

    function automatic step_t mk(input logic [2:0] op, input logic [5:0] a,
                                 input logic [5:0] b, input logic [5:0] d);
        step_t s;
        s.op    = op;
        s.src_a = a;
        s.src_b = b;
        s.dst   = d;
        return s;
    endfunction

    // microprogram: drive, predict, covariance, gains, update
    function automatic step_t prog(input logic [5:0] n);
        case (n)
            6'd0:  return mk(lqr_pkg::OP_MUL16, R_K1, R_EA, R_TA);
            6'd1:  return mk(lqr_pkg::OP_MUL16, R_K2, R_ER, R_TB);
            6'd2:  return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_TB);
            6'd3:  return mk(lqr_pkg::OP_MUL16, R_KI, R_IQ, R_TA);
            6'd4:  return mk(lqr_pkg::OP_NSUB, R_TA, R_TB, R_U);
            6'd5:  return mk(lqr_pkg::OP_MULF, R_A11, R_EA, R_TA);
            6'd6:  return mk(lqr_pkg::OP_MULF, R_A12, R_ER, R_TB);
            6'd7:  return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_X1P);
            6'd8:  return mk(lqr_pkg::OP_MULF, R_B11, R_U, R_TA);
            6'd9:  return mk(lqr_pkg::OP_ADD, R_X1P, R_TA, R_X1P);
            6'd10: return mk(lqr_pkg::OP_MULF, R_A21, R_EA, R_TA);
            6'd11: return mk(lqr_pkg::OP_MULF, R_A22, R_ER, R_TB);
            6'd12: return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_X2P);
            6'd13: return mk(lqr_pkg::OP_MULF, R_B21, R_U, R_TA);
            6'd14: return mk(lqr_pkg::OP_ADD, R_X2P, R_TA, R_X2P);
            6'd15: return mk(lqr_pkg::OP_MULF, R_A11, R_CAA, R_TA);
            6'd16: return mk(lqr_pkg::OP_MULF, R_A12, R_CRA, R_TB);
            6'd17: return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_T1);
            6'd18: return mk(lqr_pkg::OP_MULF, R_A11, R_CAR, R_TA);
            6'd19: return mk(lqr_pkg::OP_MULF, R_A12, R_CRR, R_TB);
            6'd20: return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_T2);
            6'd21: return mk(lqr_pkg::OP_MULF, R_A21, R_CAA, R_TA);
            6'd22: return mk(lqr_pkg::OP_MULF, R_A22, R_CRA, R_TB);
            6'd23: return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_T3);
            6'd24: return mk(lqr_pkg::OP_MULF, R_A21, R_CAR, R_TA);
            6'd25: return mk(lqr_pkg::OP_MULF, R_A22, R_CRR, R_TB);
            6'd26: return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_T4);
            6'd27: return mk(lqr_pkg::OP_MULF, R_T1, R_A11, R_TA);
            6'd28: return mk(lqr_pkg::OP_MULF, R_T2, R_A12, R_TB);
            6'd29: return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_P11);
            6'd30: return mk(lqr_pkg::OP_ADD, R_P11, R_Q, R_P11);
            6'd31: return mk(lqr_pkg::OP_MULF, R_T1, R_A21, R_TA);
            6'd32: return mk(lqr_pkg::OP_MULF, R_T2, R_A22, R_TB);
            6'd33: return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_P12);
            6'd34: return mk(lqr_pkg::OP_MULF, R_T3, R_A11, R_TA);
            6'd35: return mk(lqr_pkg::OP_MULF, R_T4, R_A12, R_TB);
            6'd36: return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_P21);
            6'd37: return mk(lqr_pkg::OP_MULF, R_T3, R_A21, R_TA);
            6'd38: return mk(lqr_pkg::OP_MULF, R_T4, R_A22, R_TB);
            6'd39: return mk(lqr_pkg::OP_ADD, R_TA, R_TB, R_P22);
            6'd40: return mk(lqr_pkg::OP_ADD, R_P22, R_Q, R_P22);
            6'd41: return mk(lqr_pkg::OP_ADD, R_P11, R_R, R_S);
            6'd42: return mk(lqr_pkg::OP_DIV, R_P11, R_S, R_K1G);
            6'd43: return mk(lqr_pkg::OP_DIV, R_P21, R_S, R_K2G);
            6'd44: return mk(lqr_pkg::OP_SUB, R_YQ, R_X1P, R_YERR);
            6'd45: return mk(lqr_pkg::OP_MULF, R_K1G, R_YERR, R_TA);
            6'd46: return mk(lqr_pkg::OP_ADD, R_X1P, R_TA, R_EA);
            6'd47: return mk(lqr_pkg::OP_MULF, R_K2G, R_YERR, R_TA);
            6'd48: return mk(lqr_pkg::OP_ADD, R_X2P, R_TA, R_ER);
            6'd49: return mk(lqr_pkg::OP_SUB, R_ONE, R_K1G, R_OMK);
            6'd50: return mk(lqr_pkg::OP_MULF, R_OMK, R_P11, R_CAA);
            6'd51: return mk(lqr_pkg::OP_MULF, R_OMK, R_P12, R_CAR);
            6'd52: return mk(lqr_pkg::OP_MULF, R_K2G, R_P11, R_TA);
            6'd53: return mk(lqr_pkg::OP_SUB, R_P21, R_TA, R_CRA);
            6'd54: return mk(lqr_pkg::OP_MULF, R_K2G, R_P12, R_TA);
            6'd55: return mk(lqr_pkg::OP_SUB, R_P22, R_TA, R_CRR);
            default: return mk(lqr_pkg::OP_ADD, R_ONE, R_ONE, R_TA);
        endcase
    endfunction

    // configuration registers
    logic signed [9:0]  setpoint_reg;
    logic [8:0]         offset_reg;
    logic signed [31:0] k1_reg;
    logic signed [31:0] k2_reg;
    logic signed [31:0] ki_reg;
    logic [14:0]        ilim_reg;
    logic [46:0]        qproc_reg;
    logic [46:0]        rmeas_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= 10'sd0;
            offset_reg   <= 9'd150;
            k1_reg       <= 32'sd2114591;
            k2_reg       <= 32'sd2400692;
            ki_reg       <= -32'sd65379;
            ilim_reg     <= 15'd1000;
            qproc_reg    <= 47'd1677721600;
            rmeas_reg    <= 47'd168;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SETPOINT: setpoint_reg <= cfg_wdata[9:0];
                REG_OFFSET:   offset_reg   <= cfg_wdata[8:0];
                REG_K1:       k1_reg       <= cfg_wdata[31:0];
                REG_K2:       k2_reg       <= cfg_wdata[31:0];
                REG_KI:       ki_reg       <= cfg_wdata[31:0];
                REG_ILIM:     ilim_reg     <= cfg_wdata[14:0];
                REG_QPROC:    qproc_reg    <= cfg_wdata;
                REG_RMEAS:    rmeas_reg    <= cfg_wdata;
                default:      ilim_reg     <= ilim_reg;
            endcase
        end
    end

    // state and working registers
    logic [1:0]           state_reg;
    logic [5:0]           step_reg;
    logic signed [QW-1:0] ea_reg, er_reg, caa_reg, car_reg, cra_reg, crr_reg;
    logic signed [QW-1:0] u_reg, x1p_reg, x2p_reg, ta_reg, tb_reg;
    logic signed [QW-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [QW-1:0] p11_reg, p12_reg, p21_reg, p22_reg;
    logic signed [QW-1:0] s_reg, k1g_reg, k2g_reg, yerr_reg, omk_reg;
    logic signed [15:0]   integ_reg;
    logic                 last_cw_reg;
    logic signed [10:0]   y_reg;
    logic signed [11:0]   e_reg;
    logic                 m_tvalid_reg;
    logic [127:0]         m_tdata_reg;

    step_t                cur;
    lqr_pkg::alu_req_t    alu_req;
    lqr_pkg::alu_rsp_t    alu_rsp;
    logic signed [QW-1:0] opa, opb;
    logic signed [QW-1:0] iq, yq;

    assign cur = prog(step_reg);
    assign iq  = lqr_pkg::sat_q(64'(integ_reg) <<< FB);
    assign yq  = lqr_pkg::sat_q(64'(y_reg) <<< FB);

    function automatic logic signed [QW-1:0] pick(
        input logic [5:0] c,
        input logic signed [QW-1:0] ea, er, caa, car, cra, crr,
        input logic signed [QW-1:0] k1, k2, ki, iqv, u, x1p, x2p, ta, tb,
        input logic signed [QW-1:0] t1, t2, t3, t4, p11, p12, p21, p22,
        input logic signed [QW-1:0] qv, rv, s, k1g, k2g, yqv, yerr, omk);
        case (c)
            R_EA:   return ea;
            R_ER:   return er;
            R_CAA:  return caa;
            R_CAR:  return car;
            R_CRA:  return cra;
            R_CRR:  return crr;
            R_K1:   return k1;
            R_K2:   return k2;
            R_KI:   return ki;
            R_IQ:   return iqv;
            R_A11:  return A11;
            R_A12:  return A12;
            R_A21:  return A21;
            R_A22:  return A22;
            R_B11:  return B11;
            R_B21:  return B21;
            R_U:    return u;
            R_X1P:  return x1p;
            R_X2P:  return x2p;
            R_TA:   return ta;
            R_TB:   return tb;
            R_T1:   return t1;
            R_T2:   return t2;
            R_T3:   return t3;
            R_T4:   return t4;
            R_P11:  return p11;
            R_P12:  return p12;
            R_P21:  return p21;
            R_P22:  return p22;
            R_Q:    return qv;
            R_R:    return rv;
            R_S:    return s;
            R_K1G:  return k1g;
            R_K2G:  return k2g;
            R_YQ:   return yqv;
            R_YERR: return yerr;
            R_ONE:  return lqr_pkg::QONE;
            R_OMK:  return omk;
            default: return '0;
        endcase
    endfunction

    // operand selection for the shared alu
    always_comb begin
        opa = pick(cur.src_a, ea_reg, er_reg, caa_reg, car_reg, cra_reg, crr_reg,
                   QW'(k1_reg), QW'(k2_reg), QW'(ki_reg), iq, u_reg, x1p_reg, x2p_reg,
                   ta_reg, tb_reg, t1_reg, t2_reg, t3_reg, t4_reg,
                   p11_reg, p12_reg, p21_reg, p22_reg,
                   QW'({1'b0, qproc_reg}), QW'({1'b0, rmeas_reg}), s_reg, k1g_reg, k2g_reg,
                   yq, yerr_reg, omk_reg);
        opb = pick(cur.src_b, ea_reg, er_reg, caa_reg, car_reg, cra_reg, crr_reg,
                   QW'(k1_reg), QW'(k2_reg), QW'(ki_reg), iq, u_reg, x1p_reg, x2p_reg,
                   ta_reg, tb_reg, t1_reg, t2_reg, t3_reg, t4_reg,
                   p11_reg, p12_reg, p21_reg, p22_reg,
                   QW'({1'b0, qproc_reg}), QW'({1'b0, rmeas_reg}), s_reg, k1g_reg, k2g_reg,
                   yq, yerr_reg, omk_reg);
        alu_req.start = state_reg == S_ISSUE;
        alu_req.op    = cur.op;
    end

    lqr_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (opa),
        .opb     (opb),
        .rsp     (alu_rsp)
    );

    // drive clamp on write-back
    logic signed [QW-1:0] u_clamped;
    always_comb begin
        u_clamped = alu_rsp.result;
        if (u_clamped > lqr_pkg::ULIM) u_clamped = lqr_pkg::ULIM;
        if (u_clamped < -lqr_pkg::ULIM) u_clamped = -lqr_pkg::ULIM;
    end

    // input word decode
    logic signed [10:0] y_in;
    logic signed [11:0] e_in;
    assign y_in = $signed({2'b00, s_tdata[8:0]}) - $signed({2'b00, offset_reg});
    assign e_in = 12'(setpoint_reg) - 12'(y_in);

    // drive truncation, direction, integral with anti-windup
    logic [QW-1:0]      u_mag;
    logic [12:0]        ui_mag;
    logic signed [12:0] drive;
    logic               at_neg, at_pos, add_e;
    logic signed [16:0] acc, lim17;
    logic signed [15:0] integ_next;
    logic               cw_next;
    logic               e_zero;

    always_comb begin
        u_mag   = lqr_pkg::mag_q(u_reg);
        ui_mag  = 13'(u_mag >> FB);
        drive   = u_reg[QW-1] ? -$signed(ui_mag) : $signed(ui_mag);
        at_neg  = u_reg == -lqr_pkg::ULIM;
        at_pos  = u_reg == lqr_pkg::ULIM;
        e_zero  = e_reg == 12'sd0;
        if (at_neg) add_e = e_reg < 0;
        else if (at_pos) add_e = e_reg > 0;
        else add_e = 1'b1;
        lim17 = $signed({2'b00, ilim_reg});
        acc   = 17'(integ_reg) + (add_e ? 17'(e_reg) : 17'sd0);
        if (acc > lim17) acc = lim17;
        if (acc < -lim17) acc = -lim17;
        integ_next = 16'(acc);
        cw_next = last_cw_reg;
        if (u_reg < 0) cw_next = 1'b1;
        else if (u_reg > 0) cw_next = 1'b0;
        if (e_zero) cw_next = 1'b1;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            ea_reg       <= '0;
            er_reg       <= '0;
            caa_reg      <= lqr_pkg::QONE;
            car_reg      <= '0;
            cra_reg      <= '0;
            crr_reg      <= lqr_pkg::QONE;
            integ_reg    <= '0;
            last_cw_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        y_reg     <= y_in;
                        e_reg     <= e_in;
                        step_reg  <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        case (cur.dst)
                            R_EA:   ea_reg   <= alu_rsp.result;
                            R_ER:   er_reg   <= alu_rsp.result;
                            R_CAA:  caa_reg  <= alu_rsp.result;
                            R_CAR:  car_reg  <= alu_rsp.result;
                            R_CRA:  cra_reg  <= alu_rsp.result;
                            R_CRR:  crr_reg  <= alu_rsp.result;
                            R_U:    u_reg    <= u_clamped;
                            R_X1P:  x1p_reg  <= alu_rsp.result;
                            R_X2P:  x2p_reg  <= alu_rsp.result;
                            R_TB:   tb_reg   <= alu_rsp.result;
                            R_T1:   t1_reg   <= alu_rsp.result;
                            R_T2:   t2_reg   <= alu_rsp.result;
                            R_T3:   t3_reg   <= alu_rsp.result;
                            R_T4:   t4_reg   <= alu_rsp.result;
                            R_P11:  p11_reg  <= alu_rsp.result;
                            R_P12:  p12_reg  <= alu_rsp.result;
                            R_P21:  p21_reg  <= alu_rsp.result;
                            R_P22:  p22_reg  <= alu_rsp.result;
                            R_S:    s_reg    <= alu_rsp.result;
                            R_K1G:  k1g_reg  <= alu_rsp.result;
                            R_K2G:  k2g_reg  <= alu_rsp.result;
                            R_YERR: yerr_reg <= alu_rsp.result;
                            R_OMK:  omk_reg  <= alu_rsp.result;
                            default: ta_reg  <= alu_rsp.result;
                        endcase
                        if (step_reg == LAST_STEP) begin
                            state_reg <= S_DONE;
                        end else begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        integ_reg    <= integ_next;
                        last_cw_reg  <= cw_next;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'b0, er_reg, ea_reg, drive, e_zero, cw_next,
                                         ui_mag[11:0]};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // an accepted word starts the microprogram
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_ISSUE && step_reg == '0)
        else $error("accepted word did not start the sequencer");

    // the alu answers only while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> state_reg == S_WAIT)
        else $error("alu result outside the wait state");

    // duty is the magnitude of the signed drive
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[26] ? 13'(-$signed(m_tdata[26:14])) : m_tdata[26:14])
                     == {1'b0, m_tdata[11:0]})
        else $error("duty does not match drive magnitude");

    // brake forces the clockwise direction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13] |-> m_tdata[12])
        else $error("brake without clockwise direction");

endmodule

### rtl/lqr_alu.sv
`timescale 1ns / 1ps

module lqr_alu (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lqr_pkg::alu_req_t             req,
    input  logic signed [lqr_pkg::QW-1:0] opa,
    input  logic signed [lqr_pkg::QW-1:0] opb,
    output lqr_pkg::alu_rsp_t             rsp
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_MFIN = 3'd2;
    localparam logic [2:0] A_DIV  = 3'd3;
    localparam logic [2:0] A_DFIN = 3'd4;

    localparam int QW  = lqr_pkg::QW;
    localparam int PW  = lqr_pkg::PW;
    localparam int DW  = lqr_pkg::DW;
    localparam int DCW = lqr_pkg::DCW;
    localparam int FB  = lqr_pkg::FRAC_BITS;

    logic [2:0]           state_reg;
    logic                 done_reg;
    logic signed [QW-1:0] result_reg;
    logic [QW-1:0]        ma_reg;
    logic [QW-1:0]        mb_reg;
    logic                 neg_reg;
    logic                 sh16_reg;
    logic [PW-1:0]        acc_reg;
    logic [DCW-1:0]       cnt_reg;
    logic [DW-1:0]        num_reg;
    logic [DW-1:0]        quo_reg;
    logic [QW-1:0]        rem_reg;
    logic [QW-1:0]        den_reg;

    // saturating add, subtract, negate-subtract
    logic signed [63:0]   a64;
    logic signed [63:0]   b64;
    logic signed [63:0]   nb64;
    logic signed [QW-1:0] add_res;

    assign a64  = 64'(opa);
    assign b64  = 64'(opb);
    assign nb64 = 64'(lqr_pkg::sat_q(-b64));

    always_comb begin
        case (req.op)
            lqr_pkg::OP_ADD:  add_res = lqr_pkg::sat_q(a64 + b64);
            lqr_pkg::OP_SUB:  add_res = lqr_pkg::sat_q(a64 + nb64);
            lqr_pkg::OP_NSUB: add_res = lqr_pkg::sat_q(-a64 - b64);
            default:          add_res = '0;
        endcase
    end

    // one 48x16 partial product per cycle
    logic [15:0]   mb_chunk;
    logic [63:0]   prod;
    logic [PW-1:0] pp;
    logic [5:0]    pp_sh;

    assign pp_sh    = {cnt_reg[1:0], 4'b0000};
    assign mb_chunk = 16'(mb_reg >> pp_sh);
    assign prod     = ma_reg * mb_chunk;
    assign pp       = PW'(prod) << pp_sh;

    // floor shift with sign, then saturate
    logic [PW-1:0]        mq;
    logic                 sticky;
    logic signed [QW-1:0] mul_res;

    always_comb begin
        if (sh16_reg) begin
            mq     = acc_reg >> 16;
            sticky = |acc_reg[15:0];
        end else begin
            mq     = acc_reg >> FB;
            sticky = |acc_reg[FB-1:0];
        end
        mq      = mq + PW'(neg_reg && sticky);
        mul_res = lqr_pkg::from_mag(mq, neg_reg);
    end

    // restoring divide, one quotient bit per cycle
    logic [QW:0]   rem2;
    logic          qbit;
    logic [QW-1:0] rem_next;

    assign rem2     = {rem_reg, num_reg[DW-1]};
    assign qbit     = rem2 >= {1'b0, den_reg};
    assign rem_next = qbit ? QW'(rem2 - {1'b0, den_reg}) : QW'(rem2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        ma_reg   <= lqr_pkg::mag_q(opa);
                        mb_reg   <= lqr_pkg::mag_q(opb);
                        neg_reg  <= opa[QW-1] != opb[QW-1];
                        sh16_reg <= req.op == lqr_pkg::OP_MUL16;
                        acc_reg  <= '0;
                        cnt_reg  <= '0;
                        num_reg  <= {lqr_pkg::mag_q(opa), {FB{1'b0}}};
                        den_reg  <= lqr_pkg::mag_q(opb);
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        case (req.op)
                            lqr_pkg::OP_MUL16, lqr_pkg::OP_MULF: begin
                                state_reg <= A_MUL;
                            end
                            lqr_pkg::OP_DIV: begin
                                if (opb == '0) begin
                                    result_reg <= '0;
                                    done_reg   <= 1'b1;
                                end else begin
                                    state_reg <= A_DIV;
                                end
                            end
                            default: begin
                                result_reg <= add_res;
                                done_reg   <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    acc_reg <= acc_reg + pp;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DCW'(2)) begin
                        state_reg <= A_MFIN;
                    end
                end
                A_MFIN: begin
                    result_reg <= mul_res;
                    done_reg   <= 1'b1;
                    state_reg  <= A_IDLE;
                end
                A_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[DW-2:0], qbit};
                    num_reg <= {num_reg[DW-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DCW'(DW - 1)) begin
                        state_reg <= A_DFIN;
                    end
                end
                A_DFIN: begin
                    result_reg <= lqr_pkg::from_mag(PW'(quo_reg), neg_reg);
                    done_reg   <= 1'b1;
                    state_reg  <= A_IDLE;
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // register indexes of the config port
    localparam logic [2:0] REG_SETPOINT  = 3'd0;
    localparam logic [2:0] REG_OFFSET    = 3'd1;
    localparam logic [2:0] REG_K1        = 3'd2;
    localparam logic [2:0] REG_K2        = 3'd3;
    localparam logic [2:0] REG_KI        = 3'd4;
    localparam logic [2:0] REG_ILIMIT    = 3'd5;
    localparam logic [2:0] REG_Q_PROCESS = 3'd6;
    localparam logic [2:0] REG_R_MEAS    = 3'd7;

    localparam int     FRAC_BITS = lqr_pkg::FRAC_BITS;
    localparam longint Q_HI      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Q_LO      = -Q_HI - 1;
    localparam longint Q_ONE     = 64'sd1 <<< FRAC_BITS;
    localparam longint DRIVE_LIM = longint'(lqr_pkg::DRIVE_MAX) * Q_ONE;
    localparam int     IDLE_LIMIT = 20000;
    localparam int     DRAIN_CYCLES = 600;

    // packed from the top bit down, so the last member sits at bit 0
    typedef struct packed {
        logic signed [47:0] est_rate;
        logic signed [47:0] est_angle;
        logic signed [12:0] drive_value;
        logic               brake;
        logic               turn_cw;
        logic [11:0]        pwm_duty;
    } ctrl_word_t;

    typedef struct {
        logic [8:0]  angle;
        bit          typed;
        logic [11:0] pwm_duty;
        logic        turn_cw;
        logic        brake;
        logic [12:0] drive_value;
    } angle_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;    // angle_deg[8:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;    // pwm_duty[11:0] turn_cw[12] brake[13] drive_value[26:14]
                              // est_angle_out[74:27] est_rate_out[122:75]
    logic         cfg_wr_en;
    logic [2:0]   cfg_addr;
    logic [46:0]  cfg_wdata;

    // predictor copy of registers and estimator state
    logic [9:0]  setpoint_r;
    logic [8:0]  offset_r;
    logic [31:0] k1_r, k2_r, ki_r;
    logic [14:0] ilimit_r;
    logic [46:0] qproc_r, rmeas_r;
    longint      x_ang, x_rate, p_aa, p_ar, p_ra, p_rr;
    int          integ;
    bit          cw_dir;

    ctrl_word_t  pending_words[$];
    int          n_errors;
    int          burst_left;
    int          idle_cnt;
    int          stall_span;
    bit          stall_mode;

    lqr_kalman_state_controller_unit dut (.*);

    always #6 aclk = ~aclk;

    // fixed-point helpers
    function automatic longint qsat(logic signed [127:0] v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return longint'(v);
    endfunction

    function automatic longint qadd(longint a, longint b);
        logic signed [127:0] w;
        w = qsat(a);
        w = w + qsat(b);
        return qsat(w);
    endfunction

    function automatic longint qmul(longint a, longint b, int sh);
        logic signed [127:0] pa, pb;
        pa = qsat(a);
        pb = qsat(b);
        pa = (pa * pb) >>> sh;
        return qsat(pa);
    endfunction

    function automatic longint qdiv(longint num, longint den);
        logic signed [127:0] n, d;
        d = qsat(den);
        if (d == 0) return 0;
        n = qsat(num);
        n = n <<< FRAC_BITS;
        return qsat(n / d);
    endfunction

    // q32 constant to working fraction, half away from zero
    function automatic longint round_coef(longint c32);
        int     sh;
        longint m;
        sh = 32 - FRAC_BITS;
        if (sh == 0) return c32;
        m = (c32 < 0) ? -c32 : c32;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (c32 < 0) ? -m : m;
    endfunction

    // one control tick: drive from old estimate, then kalman predict/update
    function automatic ctrl_word_t control_tick(logic [8:0] angle);
        longint a11, a12, a21, a22, b1, b2, q, r;
        longint u, ui, t1, t2, t3, t4, m11, m12, m21, m22, s, g1, g2;
        longint xp1, xp2, innov, omk;
        logic signed [127:0] w;
        int y, e, lim, acc;
        ctrl_word_t res;
        a11 = round_coef(64'sd4294108303);
        a12 = round_coef(64'sd42902428);
        a21 = round_coef(-64'sd150710402);
        a22 = round_coef(64'sd4285518368);
        b1  = round_coef(64'sd68032);
        b2  = round_coef(64'sd490915);
        q   = longint'(qproc_r);
        r   = longint'(rmeas_r);
        y   = int'(angle) - int'(offset_r);
        e   = int'($signed(setpoint_r)) - y;
        lim = int'(ilimit_r);

        u = qadd(qmul(longint'($signed(k1_r)), x_ang, 16),
                 qmul(longint'($signed(k2_r)), x_rate, 16));
        w = qmul(longint'($signed(ki_r)), longint'(integ) * Q_ONE, 16);
        w = -w - u;
        u = qsat(w);
        if (u > DRIVE_LIM) u = DRIVE_LIM;
        if (u < -DRIVE_LIM) u = -DRIVE_LIM;
        ui = (u < 0) ? -((-u) >>> FRAC_BITS) : (u >>> FRAC_BITS);

        xp1 = qadd(qadd(qmul(a11, x_ang, FRAC_BITS), qmul(a12, x_rate, FRAC_BITS)),
                   qmul(b1, u, FRAC_BITS));
        xp2 = qadd(qadd(qmul(a21, x_ang, FRAC_BITS), qmul(a22, x_rate, FRAC_BITS)),
                   qmul(b2, u, FRAC_BITS));

        // covariance predict
        t1  = qadd(qmul(a11, p_aa, FRAC_BITS), qmul(a12, p_ra, FRAC_BITS));
        t2  = qadd(qmul(a11, p_ar, FRAC_BITS), qmul(a12, p_rr, FRAC_BITS));
        t3  = qadd(qmul(a21, p_aa, FRAC_BITS), qmul(a22, p_ra, FRAC_BITS));
        t4  = qadd(qmul(a21, p_ar, FRAC_BITS), qmul(a22, p_rr, FRAC_BITS));
        m11 = qadd(qadd(qmul(t1, a11, FRAC_BITS), qmul(t2, a12, FRAC_BITS)), q);
        m12 = qadd(qmul(t1, a21, FRAC_BITS), qmul(t2, a22, FRAC_BITS));
        m21 = qadd(qmul(t3, a11, FRAC_BITS), qmul(t4, a12, FRAC_BITS));
        m22 = qadd(qadd(qmul(t3, a21, FRAC_BITS), qmul(t4, a22, FRAC_BITS)), q);

        // gains, zero when innovation variance is zero
        s  = qadd(m11, r);
        g1 = qdiv(m11, s);
        g2 = qdiv(m21, s);

        innov  = qadd(longint'(y) * Q_ONE, -xp1);
        x_ang  = qadd(xp1, qmul(g1, innov, FRAC_BITS));
        x_rate = qadd(xp2, qmul(g2, innov, FRAC_BITS));

        omk  = qadd(Q_ONE, -g1);
        p_aa = qmul(omk, m11, FRAC_BITS);
        p_ar = qmul(omk, m12, FRAC_BITS);
        p_ra = qadd(m21, -qmul(g2, m11, FRAC_BITS));
        p_rr = qadd(m22, -qmul(g2, m12, FRAC_BITS));

        if (u < 0) cw_dir = 1'b1;
        else if (u > 0) cw_dir = 1'b0;
        if (e == 0) cw_dir = 1'b1;

        // integral with anti-windup at the drive limits
        acc = integ;
        if (u == -DRIVE_LIM) begin
            if (e < 0) acc += e;
        end else if (u == DRIVE_LIM) begin
            if (e > 0) acc += e;
        end else begin
            acc += e;
        end
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        integ = acc;

        res.pwm_duty    = 12'((ui < 0) ? -ui : ui);
        res.turn_cw     = cw_dir;
        res.brake       = (e == 0);
        res.drive_value = 13'(ui);
        res.est_angle   = 48'(x_ang);
        res.est_rate    = 48'(x_rate);
        return res;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [46:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(posedge aclk);
        case (idx)
            REG_SETPOINT:  setpoint_r = val[9:0];
            REG_OFFSET:    offset_r   = val[8:0];
            REG_K1:        k1_r       = val[31:0];
            REG_K2:        k2_r       = val[31:0];
            REG_KI:        ki_r       = val[31:0];
            REG_ILIMIT:    ilimit_r   = val[14:0];
            REG_Q_PROCESS: qproc_r    = val;
            REG_R_MEAS:    rmeas_r    = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [9:0] sp, logic [8:0] off, logic [31:0] k1,
                             logic [31:0] k2, logic [31:0] ki, logic [14:0] lim,
                             logic [46:0] qp, logic [46:0] rm);
        write_reg(REG_SETPOINT, 47'(sp));
        write_reg(REG_OFFSET, 47'(off));
        write_reg(REG_K1, 47'(k1));
        write_reg(REG_K2, 47'(k2));
        write_reg(REG_KI, 47'(ki));
        write_reg(REG_ILIMIT, 47'(lim));
        write_reg(REG_Q_PROCESS, qp);
        write_reg(REG_R_MEAS, rm);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // hold off input until every pending word is back
    task automatic drain_words;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_angle(angle_row_t row);
        ctrl_word_t w;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 25)) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, row.angle};
        do @(posedge aclk); while (!s_tready);
        w = control_tick(row.angle);
        if (row.typed) begin
            w.pwm_duty    = row.pwm_duty;
            w.turn_cw     = row.turn_cw;
            w.brake       = row.brake;
            w.drive_value = row.drive_value;
        end
        pending_words.push_back(w);
    endtask

    // mostly angles close to the operating point, some wild ones
    task automatic random_angles(int count, int pause_at);
        angle_row_t row;
        int target, pick;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) drain_words();
            target = int'($signed(setpoint_r)) + int'(offset_r);
            pick   = $urandom_range(0, 9);
            if (pick < 6) target = target + $urandom_range(0, 16) - 8;
            else if (pick > 7) target = $urandom_range(0, 511);
            if (target < 0) target = 0;
            if (target > 511) target = 511;
            row = '{angle: 9'(target), typed: 1'b0, pwm_duty: '0, turn_cw: 1'b0,
                    brake: 1'b0, drive_value: '0};
            send_angle(row);
        end
        drain_words();
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        if (stall_span == 0) begin
            stall_mode = ($urandom_range(0, 2) == 0);
            stall_span = $urandom_range(10, 400);
        end
        stall_span--;
        m_tready = stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // compare each returned word against the oldest prediction
    always @(posedge aclk) begin
        ctrl_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = ctrl_word_t'(m_tdata[122:0]);
            if (pending_words.size() == 0) begin
                $error("unexpected word %h", m_tdata[122:0]);
                n_errors++;
            end else begin
                want = pending_words.pop_front();
                if (got.pwm_duty !== want.pwm_duty) begin
                    $error("pwm_duty exp %0d got %0d", want.pwm_duty, got.pwm_duty);
                    n_errors++;
                end
                if (got.turn_cw !== want.turn_cw) begin
                    $error("turn_cw exp %0d got %0d", want.turn_cw, got.turn_cw);
                    n_errors++;
                end
                if (got.brake !== want.brake) begin
                    $error("brake exp %0d got %0d", want.brake, got.brake);
                    n_errors++;
                end
                if (got.drive_value !== want.drive_value) begin
                    $error("drive_value exp %0d got %0d", want.drive_value, got.drive_value);
                    n_errors++;
                end
                if (got.est_angle !== want.est_angle) begin
                    $error("est_angle_out exp %0d got %0d", want.est_angle, got.est_angle);
                    n_errors++;
                end
                if (got.est_rate !== want.est_rate) begin
                    $error("est_rate_out exp %0d got %0d", want.est_rate, got.est_rate);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        angle_row_t table_rows[];
        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = REG_SETPOINT;
        cfg_wdata  = '0;
        n_errors   = 0;
        burst_left = 0;
        idle_cnt   = 0;
        stall_span = 0;
        stall_mode = 1'b0;

        // reset values of registers and estimator
        setpoint_r = 10'd0;
        offset_r   = 9'd150;
        k1_r       = 32'd2114591;
        k2_r       = 32'd2400692;
        ki_r       = -32'sd65379;
        ilimit_r   = 15'd1000;
        qproc_r    = 47'd1677721600;
        rmeas_r    = 47'd168;
        x_ang = 0; x_rate = 0; p_ar = 0; p_ra = 0;
        p_aa = Q_ONE; p_rr = Q_ONE;
        integ  = 0;
        cw_dir = 1'b0;

        // first row: zero estimate and zero error after reset -> no drive, brake
        table_rows = '{
            '{9'd150, 1'b1, 12'd0, 1'b1, 1'b1, 13'd0},
            '{9'd0,   1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd511, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd359, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd150, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd149, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd151, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd256, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd255, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd0,   1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd0,   1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd511, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd510, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd1,   1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd170, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd130, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd150, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd150, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd2,   1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd64,  1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
            '{9'd300, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0}
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed rows at reset settings
        foreach (table_rows[i]) send_angle(table_rows[i]);
        drain_words();

        // reset settings, random angles, one full pause half way
        random_angles(250, 120);

        // upper extremes, large noise values
        configure(10'h200, 9'h1FF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  15'h7FFF, 47'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF);
        random_angles(40, -1);

        // other extremes; zero noise drives the innovation variance to zero
        configure(10'h1FF, 9'h000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  15'h0000, 47'h0, 47'h0);
        random_angles(40, -1);

        // random moderate settings
        configure(10'($urandom_range(0, 540)) - 10'd180, 9'($urandom_range(0, 359)),
                  32'($urandom_range(0, 4000000)), 32'($urandom_range(0, 4000000)),
                  32'($urandom_range(0, 200000)) - 32'd100000,
                  15'($urandom_range(0, 32767)), 47'($urandom_range(0, 32'h7FFF_FFFF)),
                  47'($urandom_range(0, 100000)));
        random_angles(200, -1);

        // back to the reset values
        configure(10'd0, 9'd150, 32'd2114591, 32'd2400692, -32'sd65379, 15'd1000,
                  47'd1677721600, 47'd168);
        random_angles(200, -1);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0 && pending_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
rtl/lqr_pkg.sv
rtl/lqr_alu.sv
rtl/lqr_kalman_state_controller_unit.sv
verif/testbench.sv
